// ----- rtl/core/base64_stream_encoder_defines.svh -----
// assertion macros for the base64 stream encoder back end
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define B64E_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/b64e_pkg.sv -----
// types, constants and the alphabet lookup for the base64 stream encoder
`timescale 1ns / 1ps

package b64e_pkg;

    localparam int LINE_LEN_W = 10;
    localparam int SEXTET_W   = 7;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [SEXTET_W-1:0] PAD_INDEX = 7'd64;
    localparam logic [7:0]          LINE_FEED = 8'h0A;

    localparam logic [7:0] MASK_FC = 8'hFC;
    localparam logic [7:0] MASK_03 = 8'h03;
    localparam logic [7:0] MASK_F0 = 8'hF0;
    localparam logic [7:0] MASK_0F = 8'h0F;
    localparam logic [7:0] MASK_C0 = 8'hC0;
    localparam logic [7:0] MASK_3F = 8'h3F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } t_out_item;

    // one group of four alphabet indexes, index 0 goes out first
    typedef struct packed {
        logic [3:0][SEXTET_W-1:0] sextet;
        logic                     last;
    } t_group;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // index 0..63 to the standard alphabet, anything above to the pad
    function automatic logic [7:0] b64_char(input logic [SEXTET_W-1:0] idx);
        logic [7:0] wide;
        wide = {1'b0, idx};
        if (idx < 7'd26) begin
            b64_char = 8'h41 + wide;
        end else if (idx < 7'd52) begin
            b64_char = 8'h61 + wide - 8'd26;
        end else if (idx < 7'd62) begin
            b64_char = 8'h30 + wide - 8'd52;
        end else if (idx == 7'd62) begin
            b64_char = 8'h2B;
        end else if (idx == 7'd63) begin
            b64_char = 8'h2F;
        end else begin
            b64_char = 8'h3D;
        end
    endfunction

endpackage

// ----- rtl/core/base64_stream_encoder.sv -----
// top level of the base64 stream encoder with optional line wrapping
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_in_data  (data_byte, last_byte)
// out       output     o_out_valid / i_out_ready o_out_data (out_char, out_last)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (line_length)
//
// the front takes one item per cycle while the group queue has room
// the back sends one character per cycle while the output is not stalled: four per group
// plus any line feeds, so a group of three bytes leaves as 4 to 8 characters
// without wrapping a group of three bytes leaves as four characters
// reset is synchronous, active low, and needs no clearing pass
// a stalled output holds its item while the front keeps filling the queue

module base64_stream_encoder
    import b64e_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LINE_LEN_W-1:0] i_cfg_data
);

    // line length register, zero turns wrapping off
    logic [LINE_LEN_W-1:0] r_line_len;

    // groups travel from front to back through the queue
    logic      push;
    logic      pop;
    t_group    front_group;
    t_group    back_group;
    t_q_status q_status;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
        end else if (i_cfg_valid) begin
            r_line_len <= i_cfg_data;
        end
    end

    // byte gathering and sextet split
    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_group    (front_group)
    );

    // decouples the byte side from the character side
    b64e_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_group  (front_group),
        .i_pop    (pop),
        .o_group  (back_group),
        .o_status (q_status)
    );

    // character serializer with column count and line feeds
    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_line_len  (r_line_len),
        .i_group     (back_group),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/core/b64e_front.sv -----
// front end: gathers bytes into groups of up to three and splits them into sextets
`timescale 1ns / 1ps

module b64e_front
    import b64e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_group    o_group
);

    logic [15:0] r_held;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic [1:0]  count;
    logic        accept;
    logic        group_done;
    logic [7:0]  b0, b1, b2;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign count      = r_cnt + 2'd1;
    assign group_done = (r_cnt == 2'd2) || i_in_data.last_byte;
    assign o_push     = accept && group_done;

    always_comb begin
        b0 = r_held[15:8];
        b1 = r_held[7:0];
        b2 = i_in_data.data_byte;
        case (r_cnt)
            2'd0: begin
                b0 = i_in_data.data_byte;
                b1 = 8'd0;
                b2 = 8'd0;
            end
            2'd1: begin
                b1 = i_in_data.data_byte;
                b2 = 8'd0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_group.last      = i_in_data.last_byte;
        o_group.sextet[0] = SEXTET_W'((b0 & MASK_FC) >> 2);
        o_group.sextet[1] = SEXTET_W'(((b0 & MASK_03) << 4) | ((b1 & MASK_F0) >> 4));
        o_group.sextet[2] = (count >= 2'd2)
            ? SEXTET_W'(((b1 & MASK_0F) << 2) | ((b2 & MASK_C0) >> 6)) : PAD_INDEX;
        o_group.sextet[3] = (count == 2'd3) ? SEXTET_W'(b2 & MASK_3F) : PAD_INDEX;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = group_done ? 2'd0 : count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !group_done) begin
            if (r_cnt == 2'd0) begin
                r_held[15:8] <= i_in_data.data_byte;
            end else begin
                r_held[7:0] <= i_in_data.data_byte;
            end
        end
    end

endmodule

// ----- rtl/core/b64e_queue.sv -----
// short group queue between front and back
`timescale 1ns / 1ps

module b64e_queue
    import b64e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_group    i_group,
    input  logic      i_pop,
    output t_group    o_group,
    output t_q_status o_status
);

    t_group               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_status.empty = (r_cnt == Q_CNT_W'(0));
    assign o_status.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_group        = r_mem[r_rd_ptr];

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + Q_PTR_W'(1);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

endmodule

// ----- rtl/core/b64e_back.sv -----
// back end: sends group characters one by one, inserts line feeds
`timescale 1ns / 1ps
`include "base64_stream_encoder_defines.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [LINE_LEN_W-1:0] i_line_len,
    input  t_group                i_group,
    input  t_q_status             i_q_status,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    logic [1:0]            r_k, n_k;
    logic                  r_lf_pend, n_lf_pend;
    logic                  r_lf_last, n_lf_last;
    logic [LINE_LEN_W-1:0] r_col, n_col;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;
    logic                  out_free;
    logic [LINE_LEN_W-1:0] col_next;
    logic                  wrap;
    logic                  grp_end;
    logic                  grp_last;

    assign out_free    = !r_out_valid || i_out_ready;
    assign col_next    = r_col + LINE_LEN_W'(1);
    assign wrap        = (i_line_len != '0) && (col_next >= i_line_len);
    assign grp_end     = (r_k == 2'd3);
    assign grp_last    = grp_end && i_group.last;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_k         = r_k;
        n_lf_pend   = r_lf_pend;
        n_lf_last   = r_lf_last;
        n_col       = r_col;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (out_free) begin
            if (r_lf_pend) begin
                n_out_valid    = 1'b1;
                n_out.out_char = LINE_FEED;
                n_out.out_last = r_lf_last;
                n_lf_pend      = 1'b0;
            end else if (!i_q_status.empty) begin
                n_out_valid    = 1'b1;
                n_out.out_char = b64_char(i_group.sextet[r_k]);
                n_out.out_last = grp_last && !wrap;
                n_lf_pend      = wrap;
                n_lf_last      = grp_last;
                n_col          = (wrap || grp_last) ? '0 : col_next;
                n_k            = r_k + 2'd1;
                o_pop          = grp_end;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= 2'd0;
            r_lf_pend   <= 1'b0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_k         <= n_k;
            r_lf_pend   <= n_lf_pend;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lf_last <= n_lf_last;
        r_out     <= n_out;
    end

    `B64E_ASSERT_NOW(a_mid_group_has_entry, i_clk, i_rst_n, r_k != 2'd0, !i_q_status.empty, "group index moved without a queued group")
    `B64E_ASSERT_NOW(a_lf_behind_char, i_clk, i_rst_n, r_lf_pend, r_out_valid, "line feed pending with empty output slot")
    `B64E_ASSERT_NEXT(a_lf_sent, i_clk, i_rst_n, r_lf_pend && out_free, r_out_valid && (r_out.out_char == LINE_FEED), "pending line feed not sent")

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the base64 stream encoder with line wrapping
`timescale 1ns / 1ps

module testbench;
    import b64e_pkg::*;

    // cycles allowed for the block to settle once the last character has left
    localparam int SETTLE_CYCLES = 16;
    // cycles with no handshake on any channel before the run is called hung
    localparam int STALL_LIMIT   = 5000;
    // alphabet plus pad, first character in the top byte
    localparam logic [65*8-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LINE_LEN_W-1:0] cfg_data  = '0;

    // encoder state mirrored on the testbench side
    logic [LINE_LEN_W-1:0] enc_line_len = '0;
    logic [15:0]           enc_held     = '0;
    logic [1:0]            enc_count    = '0;
    logic [LINE_LEN_W-1:0] enc_column   = '0;

    t_out_item pending_chars[$];   // characters still owed by the block
    t_out_item group_chars[$];     // characters of the group being encoded

    int  error_count  = 0;
    int  quiet_cycles = 0;
    bit  tx_idle_en   = 1'b0;
    bit  rx_idle_en   = 1'b0;
    int  rx_hold      = 0;
    int  rx_gap       = 0;
    int  random_items = 0;

    always #1 i_clk = ~i_clk;

    base64_stream_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // one alphabet character, then a line feed if the line is full
    task automatic emit_sextet(input logic [6:0] idx);
        t_out_item c;
        c.out_char = ALPHABET[(64 - int'(idx))*8 +: 8];
        c.out_last = 1'b0;
        group_chars.push_back(c);
        enc_column = enc_column + 1'b1;   // wraps at 10 bits like the block
        if (enc_line_len != '0 && enc_column >= enc_line_len) begin
            c.out_char = LINE_FEED;
            group_chars.push_back(c);
            enc_column = '0;
        end
    endtask

    // update the mirrored state for one accepted item, queue what it causes
    task automatic encode_byte(input t_in_item it);
        logic [2:0] cnt;
        logic [7:0] b0, b1, b2;
        t_out_item  c;
        cnt = {1'b0, enc_count} + 3'd1;
        if (cnt < 3'd3 && !it.last_byte) begin
            // partial group: only held
            if (enc_count == 2'd0) begin
                enc_held = {it.data_byte, 8'h00};
            end else begin
                enc_held[7:0] = it.data_byte;
            end
            enc_count = cnt[1:0];
        end else begin
            b0 = (enc_count == 2'd0) ? it.data_byte : enc_held[15:8];
            b1 = (enc_count == 2'd0) ? 8'h00 :
                 (enc_count == 2'd1) ? it.data_byte : enc_held[7:0];
            b2 = (enc_count == 2'd2) ? it.data_byte : 8'h00;
            emit_sextet({1'b0, b0[7:2]});
            emit_sextet({1'b0, b0[1:0], b1[7:4]});
            emit_sextet(cnt >= 3'd2 ? {1'b0, b1[3:0], b2[7:6]} : PAD_INDEX);
            emit_sextet(cnt == 3'd3 ? {1'b0, b2[5:0]} : PAD_INDEX);
            // last flag rides on the final character, line feed included
            for (int i = 0; i < group_chars.size(); i++) begin
                c = group_chars[i];
                if (it.last_byte && i == group_chars.size() - 1) begin
                    c.out_last = 1'b1;
                end
                pending_chars.push_back(c);
            end
            group_chars.delete();
            enc_held  = '0;
            enc_count = '0;
            if (it.last_byte) begin
                enc_column = '0;   // next message starts on a fresh line
            end
        end
    endtask

    // ------------------------------------------------------------------
    // checking: every accepted character against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected item: out_char %h out_last %b",
                       out_data.out_char, out_data.out_last);
                error_count++;
            end else begin
                want = pending_chars.pop_front();
                if (out_data.out_char !== want.out_char) begin
                    $error("out_char expected %h actual %h",
                           want.out_char, out_data.out_char);
                    error_count++;
                end
                if (out_data.out_last !== want.out_last) begin
                    $error("out_last expected %b actual %b",
                           want.out_last, out_data.out_last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: counts cycles in which no channel moves an item
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: long hold-offs on request, random stall bursts otherwise
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_ready <= 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                out_ready <= 1'b0;
                rx_gap--;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                // this cycle starts a stall burst of random length
                out_ready <= 1'b0;
                rx_gap = $urandom_range(1, 14) - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // offer one item, hold it until taken, predict on acceptance
    task automatic send_byte(input logic [7:0] data, input logic last);
        t_in_item it;
        int       gap;
        it.data_byte = data;
        it.last_byte = last;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        encode_byte(it);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // stop offering, wait for every owed character, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_line_length(input logic [LINE_LEN_W-1:0] len);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge i_clk); while (!cfg_ready);
        enc_line_len = len;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [LINE_LEN_W-1:0] pick_line_length();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 10'd1;
            2: return 10'd1023;
            3: return 10'($urandom_range(2, 8));
            4: return 10'($urandom_range(9, 80));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // wrapping off: one and two byte groups get padded, three bytes do not
    task automatic test_group_padding();
        write_line_length('0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // shortest line, wrap right after the last character, longest line
    task automatic test_line_wrap();
        write_line_length(10'd1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_line_length(10'd4);
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h83, 1'b1);
        write_line_length(10'd1023);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    // line length lowered below the current column in the middle of a message
    task automatic test_lowered_mid_line();
        write_line_length(10'd10);
        for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        write_line_length(10'd3);
        send_message(3);
    endtask

    // long line with wrapping off, then a short line length far below the column
    task automatic test_long_line();
        write_line_length('0);
        for (int i = 0; i < 45; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        write_line_length(10'd2);
        send_message(3);
    endtask

    // random messages, random settings, some changed between groups
    task automatic test_random_messages();
        int len, head;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (random_items < 100) begin
            if ($urandom_range(0, 3) == 0) write_line_length(pick_line_length());
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 9);
            if (len > 3 && $urandom_range(0, 7) == 0) begin
                // stop on a group boundary, retune, then finish the message
                head = 3 * $urandom_range(1, (len - 1) / 3);
                for (int i = 0; i < head; i++)
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                write_line_length(pick_line_length());
                send_message(len - head);
            end else begin
                send_message(len);
            end
            random_items += len;
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_hold();
        write_line_length(10'd5);
        rx_hold = 400;
        for (int i = 0; i < 4; i++) send_message($urandom_range(6, 12));
    endtask

    // sender stops mid-message until everything owed has come out
    task automatic test_sender_pause();
        for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_drained();
        send_message(5);
    endtask

    // no idling on either side for the tail of the run
    task automatic test_quiet_tail();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_line_length(10'($urandom_range(2, 12)));
        send_message(13);
        send_message(17);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_group_padding();
        test_line_wrap();
        test_lowered_mid_line();
        test_long_line();
        test_random_messages();
        test_output_hold();
        test_sender_pause();
        test_quiet_tail();
        wait_drained();
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
